@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL. Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property checked on every rising clock edge outside reset.
`define SRWO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition that must never hold outside reset.
`define SRWO_ASSERT_NEVER(lbl, cond, msg) \
  `SRWO_ASSERT(lbl, !(cond), msg)
`else
`define SRWO_ASSERT(lbl, prop, msg)
`define SRWO_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

@@ rtl/core/srwo_pkg.sv @@
`default_nettype none

package srwo_pkg;

  localparam int unsigned SrwoQueueDepth = 4;

  localparam logic [15:0] AddrGain0    = 16'h8882;
  localparam logic [15:0] AddrGain1    = 16'h8884;
  localparam logic [15:0] AddrGain2    = 16'h8886;
  localparam logic [15:0] AddrGain3    = 16'h8888;
  localparam logic [15:0] AddrPreampLo = 16'h0008;
  localparam logic [15:0] AddrPreampHi = 16'h000B;
  localparam logic [15:0] AddrFe       = 16'h00FE;
  localparam logic [15:0] AddrBlackRef = 16'h8880;
  localparam logic [15:0] AddrTopOb    = 16'h82F3;

  localparam logic [3:0] CsMain  = 4'd2;
  localparam logic [3:0] CsAlt   = 4'd4;
  localparam logic [3:0] CsBlack = 4'd6;

  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 14;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_ENABLE     = 3'd0,
    CFG_GAIN       = 3'd1,
    CFG_PREAMP     = 3'd2,
    CFG_FE         = 3'd3,
    CFG_BLACK_REF  = 3'd4,
    CFG_TOP_OB     = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    RULE_NONE,
    RULE_GAIN,
    RULE_PREAMP,
    RULE_FE,
    RULE_BLACK_REF,
    RULE_TOP_OB
  } rule_e;

  typedef struct packed {
    logic [3:0]  chip_select;
    logic [15:0] reg_addr;
    logic [15:0] reg_value;
  } srwo_in_t;

  typedef struct packed {
    logic [15:0] out_addr;
    logic [15:0] out_value;
    logic [15:0] seen_gain;
    logic [15:0] seen_preamp;
    logic [15:0] seen_fe;
    logic [15:0] seen_black_ref;
    logic [15:0] seen_top_ob;
  } srwo_out_t;

  typedef struct packed {
    logic               enable;
    logic [12:0]        gain_override;
    logic signed [9:0]  preamp_target;
    logic signed [3:0]  fe_override;
    logic [13:0]        black_ref_override;
    logic signed [11:0] top_ob_override;
  } srwo_cfg_t;

  // One classified write as it waits between front and back.
  typedef struct packed {
    rule_e       rule;
    logic        cap;      // capture the incoming value into the rule's default
    logic        repl_en;  // replacement or adjustment is active
    logic [15:0] repl;     // replacement value, or preamp target
    logic [15:0] aux;      // Gray-decoded value for the top OB rule
    logic [15:0] addr;
    logic [15:0] value;
  } srwo_op_t;

  function automatic logic [15:0] gray_decode16(input logic [15:0] g);
    logic [15:0] v;
    for (int i = 0; i < 16; i++) begin
      v[i] = ^(g >> i);
    end
    return v;
  endfunction

  function automatic logic [15:0] gray_encode12(input logic [11:0] x);
    return {4'b0, x ^ (x >> 1)};
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/srwo_front.sv @@
`default_nettype none

module srwo_front (
  input  srwo_pkg::srwo_cfg_t cfg_i,
  input  srwo_pkg::srwo_in_t  in_i,
  output srwo_pkg::srwo_op_t  op_o
);
  import srwo_pkg::*;

  logic cs24;

  assign cs24 = (in_i.chip_select == CsMain) || (in_i.chip_select == CsAlt);

  always_comb begin
    op_o         = '0;
    op_o.rule    = RULE_NONE;
    op_o.addr    = in_i.reg_addr;
    op_o.value   = in_i.reg_value;
    op_o.aux     = gray_decode16(in_i.reg_value);
    if (cfg_i.enable) begin
      if ((in_i.reg_addr inside {AddrGain0, AddrGain1, AddrGain2, AddrGain3}) && cs24) begin
        op_o.rule    = RULE_GAIN;
        op_o.cap     = (in_i.reg_addr == AddrGain0) && (in_i.chip_select == CsMain);
        op_o.repl_en = (cfg_i.gain_override != '0);
        op_o.repl    = {3'b0, cfg_i.gain_override};
      end else if ((in_i.reg_addr inside {[AddrPreampLo:AddrPreampHi]}) && cs24) begin
        op_o.rule    = RULE_PREAMP;
        op_o.cap     = (in_i.reg_addr == AddrPreampLo) && (in_i.chip_select == CsMain);
        op_o.repl_en = !cfg_i.preamp_target[9];
        op_o.repl    = {6'b0, cfg_i.preamp_target};
      end else if ((in_i.reg_addr == AddrFe) && cs24) begin
        op_o.rule    = RULE_FE;
        op_o.cap     = (in_i.chip_select == CsMain);
        op_o.repl_en = !cfg_i.fe_override[3];
        op_o.repl    = {12'b0, cfg_i.fe_override};
      end else if ((in_i.reg_addr == AddrBlackRef) && (in_i.chip_select == CsBlack)) begin
        // Capture of the first nonzero default is decided in the back end,
        // which owns the captured value.
        op_o.rule    = RULE_BLACK_REF;
        op_o.repl_en = (cfg_i.black_ref_override != '0);
        op_o.repl    = {2'b0, cfg_i.black_ref_override};
      end else if (in_i.reg_addr == AddrTopOb) begin
        op_o.rule    = RULE_TOP_OB;
        op_o.cap     = 1'b1;
        op_o.repl_en = !cfg_i.top_ob_override[11];
        op_o.repl    = gray_encode12(cfg_i.top_ob_override);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/srwo_queue.sv @@
`default_nettype none

`include "assert_macros.svh"

module srwo_queue #(
  parameter int unsigned Depth = srwo_pkg::SrwoQueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  srwo_pkg::srwo_op_t push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output srwo_pkg::srwo_op_t pop_data_o
);
  import srwo_pkg::*;

  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth = $clog2(Depth + 1);
  localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);

  srwo_op_t            mem_q [Depth];
  logic [PtrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0] count_q, count_d;

  assign full_o     = (count_q == CntWidth'(Depth));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `SRWO_ASSERT_NEVER(a_no_overflow, push_i && full_o && !pop_i, "queue push while full")
  `SRWO_ASSERT_NEVER(a_no_underflow, pop_i && !valid_o, "queue pop while empty")
  `SRWO_ASSERT(a_count_track, 1'b1 |=> (count_q == $past(count_q) + CntWidth'($past(push_i)) - CntWidth'($past(pop_i))), "queue count lost track")

endmodule

`default_nettype wire

@@ rtl/core/srwo_back.sv @@
`default_nettype none

`include "assert_macros.svh"

module srwo_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                op_valid_i,
  input  srwo_pkg::srwo_op_t  op_i,
  output logic                op_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output srwo_pkg::srwo_out_t out_o
);
  import srwo_pkg::*;

  logic [15:0] gain_q, gain_d;
  logic [15:0] preamp_q, preamp_d;
  logic [15:0] fe_q, fe_d;
  logic [15:0] black_q, black_d;
  logic [15:0] top_ob_q, top_ob_d;
  logic [15:0] value;
  logic        out_valid_q;
  srwo_out_t   out_q;

  assign op_pop_o    = op_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    gain_d   = gain_q;
    preamp_d = preamp_q;
    fe_d     = fe_q;
    black_d  = black_q;
    top_ob_d = top_ob_q;
    value    = op_i.repl_en ? op_i.repl : op_i.value;
    case (op_i.rule)
      RULE_NONE: begin
        value = op_i.value;
      end
      RULE_GAIN: begin
        if (op_i.cap) gain_d = op_i.value;
      end
      RULE_PREAMP: begin
        if (op_i.cap) preamp_d = op_i.value;
        // Shift by the distance between target and the captured default.
        value = op_i.repl_en ? (op_i.value + op_i.repl - preamp_d) : op_i.value;
      end
      RULE_FE: begin
        if (op_i.cap) fe_d = op_i.value;
      end
      RULE_BLACK_REF: begin
        if (black_q == '0) black_d = op_i.value;
      end
      RULE_TOP_OB: begin
        top_ob_d = op_i.aux;
      end
      default: begin
        value = op_i.value;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q      <= '0;
      preamp_q    <= '0;
      fe_q        <= '0;
      black_q     <= '0;
      top_ob_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (op_pop_o) begin
        gain_q   <= gain_d;
        preamp_q <= preamp_d;
        fe_q     <= fe_d;
        black_q  <= black_d;
        top_ob_q <= top_ob_d;
      end
      if (op_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_pop_o) begin
      out_q.out_addr       <= op_i.addr;
      out_q.out_value      <= value;
      out_q.seen_gain      <= gain_d;
      out_q.seen_preamp    <= preamp_d;
      out_q.seen_fe        <= fe_d;
      out_q.seen_black_ref <= black_d;
      out_q.seen_top_ob    <= top_ob_d;
    end
  end

  `SRWO_ASSERT(a_pop_fills_out, op_pop_o |=> out_valid_q, "popped write did not reach the output")
  `SRWO_ASSERT(a_black_sticky, (black_q != '0) |=> (black_q == $past(black_q)), "black reference default changed after capture")
  `SRWO_ASSERT(a_out_hold, (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_q)), "waiting result changed or dropped")

endmodule

`default_nettype wire

@@ rtl/core/sensor_reg_write_override_unit.sv @@
// Sensor register write filter. Each beat on the input channel is one register write
// (chip select, address, value); each beat on the output channel is its result: the
// address unchanged, the value after any override or adjustment, and the five captured
// defaults as they stand after that write. While enabled, the block rewrites the fine
// gain registers, shifts the preamp registers by target minus captured default, replaces
// register 0xFE, the black reference on select 6 and the Gray-coded top optical black
// size; everything else, including the terminator, passes unchanged. The block takes one
// beat per clock cycle and returns one result per cycle while its queue has room and the
// output is taken. An accepted write is first written into the queue; the back end then
// loads the output register from the queue head once that register is free or being
// taken. The queue of Depth entries between front and back absorbs a stalled output;
// input ready drops only when that queue is full. Configuration registers are written
// through the plain write port and must only change while the block is idle.
`default_nettype none

module sensor_reg_write_override_unit #(
  parameter int unsigned Depth = srwo_pkg::SrwoQueueDepth
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [srwo_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [srwo_pkg::CfgDataWidth-1:0]    cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  srwo_pkg::srwo_in_t                   in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output srwo_pkg::srwo_out_t                  out_o
);
  import srwo_pkg::*;

  srwo_cfg_t cfg_q;
  srwo_op_t  front_op;
  srwo_op_t  head_op;
  logic      queue_full;
  logic      queue_valid;
  logic      queue_pop;
  logic      push;

  // Configuration register file. Indexes past the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable             <= 1'b0;
      cfg_q.gain_override      <= '0;
      cfg_q.preamp_target      <= '1;
      cfg_q.fe_override        <= '1;
      cfg_q.black_ref_override <= '0;
      cfg_q.top_ob_override    <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ENABLE:    cfg_q.enable             <= cfg_wdata_i[0];
        CFG_GAIN:      cfg_q.gain_override      <= cfg_wdata_i[12:0];
        CFG_PREAMP:    cfg_q.preamp_target      <= cfg_wdata_i[9:0];
        CFG_FE:        cfg_q.fe_override        <= cfg_wdata_i[3:0];
        CFG_BLACK_REF: cfg_q.black_ref_override <= cfg_wdata_i[13:0];
        CFG_TOP_OB:    cfg_q.top_ob_override    <= cfg_wdata_i[11:0];
        default: begin
        end
      endcase
    end
  end

  // The front end classifies each accepted beat in the cycle it arrives.
  assign in_ready_o = !queue_full;
  assign push       = in_valid_i && in_ready_o;

  srwo_front u_front (
    .cfg_i (cfg_q),
    .in_i  (in_i),
    .op_o  (front_op)
  );

  // Classified writes wait here; the back end drains them in order.
  srwo_queue #(
    .Depth (Depth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_op),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .valid_o     (queue_valid),
    .pop_data_o  (head_op)
  );

  // The back end owns the captured defaults and the output register.
  srwo_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (queue_valid),
    .op_i        (head_op),
    .op_pop_o    (queue_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`default_nettype none

module testbench;
  import srwo_pkg::*;

  // Spare register indexes beyond the last register. Writes to them must be ignored.
  localparam logic [CfgIdxWidth-1:0] CfgIdxSpare0 = 3'd6;
  localparam logic [CfgIdxWidth-1:0] CfgIdxSpare1 = 3'd7;

  // End-of-table marker on the register bus. It must match no rule.
  localparam logic [15:0] AddrTerminator  = 16'hFFFF;
  localparam logic [15:0] ValueTerminator = 16'hFFFF;

  // Cycles without any beat or register write before the run is declared hung.
  // The slowest correct case is the largest sender gap plus the largest receiver
  // gap behind a short queue, so this leaves a wide margin.
  localparam int unsigned StallLimit = 2000;

  // Beats after the last result that are still watched for a stray result.
  localparam int unsigned DrainCycles = 8;

  localparam int unsigned RandomPhases  = 8;
  localparam int unsigned WritesPerPhase = 78;

  // Predicts the filtered write for every accepted input beat, keeps the results
  // still to come in order, and compares each output beat with the oldest one.
  class override_scoreboard;
    srwo_cfg_t   cfg;
    logic [15:0] default_gain;
    logic [15:0] default_preamp;
    logic [15:0] default_fe;
    logic [15:0] default_black_ref;
    logic [15:0] default_ob_size;
    srwo_out_t   filtered_writes[$];
    int unsigned mismatches;
    int unsigned results_checked;

    function new();
      cfg.enable             = 1'b0;
      cfg.gain_override      = '0;
      cfg.preamp_target      = -10'sd1;
      cfg.fe_override        = -4'sd1;
      cfg.black_ref_override = '0;
      cfg.top_ob_override    = -12'sd1;
      default_gain      = '0;
      default_preamp    = '0;
      default_fe        = '0;
      default_black_ref = '0;
      default_ob_size   = '0;
      mismatches      = 0;
      results_checked = 0;
    endfunction

    function void apply_setting(logic [CfgIdxWidth-1:0] idx, logic [CfgDataWidth-1:0] data);
      case (idx)
        CFG_ENABLE:    cfg.enable             = data[0];
        CFG_GAIN:      cfg.gain_override      = data[12:0];
        CFG_PREAMP:    cfg.preamp_target      = data[9:0];
        CFG_FE:        cfg.fe_override        = data[3:0];
        CFG_BLACK_REF: cfg.black_ref_override = data[13:0];
        CFG_TOP_OB:    cfg.top_ob_override    = data[11:0];
        default: ;
      endcase
    endfunction

    function logic [15:0] gray_to_binary(logic [15:0] g);
      logic [15:0] b;
      b[15] = g[15];
      for (int i = 14; i >= 0; i--) begin
        b[i] = b[i+1] ^ g[i];
      end
      return b;
    endfunction

    function srwo_out_t filter_write(srwo_in_t w);
      srwo_out_t   r;
      logic [15:0] v;
      logic [11:0] ob;
      logic        main_or_alt;
      v  = w.reg_value;
      ob = cfg.top_ob_override;
      main_or_alt = (w.chip_select == CsMain) || (w.chip_select == CsAlt);
      if (cfg.enable) begin
        if ((w.reg_addr == AddrGain0 || w.reg_addr == AddrGain1 ||
             w.reg_addr == AddrGain2 || w.reg_addr == AddrGain3) && main_or_alt) begin
          if (w.reg_addr == AddrGain0 && w.chip_select == CsMain) default_gain = v;
          if (cfg.gain_override != '0) v = {3'b000, cfg.gain_override};
        end else if (w.reg_addr >= AddrPreampLo && w.reg_addr <= AddrPreampHi &&
                     main_or_alt) begin
          // The default is captured before the shift, so the capturing write
          // itself comes out at the target.
          if (w.reg_addr == AddrPreampLo && w.chip_select == CsMain) default_preamp = v;
          if (!cfg.preamp_target[9]) v = v + {6'b0, cfg.preamp_target} - default_preamp;
        end else if (w.reg_addr == AddrFe && main_or_alt) begin
          if (w.chip_select == CsMain) default_fe = v;
          if (!cfg.fe_override[3]) v = {12'b0, cfg.fe_override};
        end else if (w.reg_addr == AddrBlackRef && w.chip_select == CsBlack) begin
          if (default_black_ref == '0) default_black_ref = v;
          if (cfg.black_ref_override != '0) v = {2'b00, cfg.black_ref_override};
        end else if (w.reg_addr == AddrTopOb) begin
          default_ob_size = gray_to_binary(v);
          if (!ob[11]) v = {4'b0, ob ^ (ob >> 1)};
        end
      end
      r.out_addr       = w.reg_addr;
      r.out_value      = v;
      r.seen_gain      = default_gain;
      r.seen_preamp    = default_preamp;
      r.seen_fe        = default_fe;
      r.seen_black_ref = default_black_ref;
      r.seen_top_ob    = default_ob_size;
      return r;
    endfunction

    function void note_write(srwo_in_t w);
      filtered_writes.push_back(filter_write(w));
    endfunction

    function int unsigned pending();
      return filtered_writes.size();
    endfunction

    task report(string msg);
      $display("[%0t] ERROR: %s", $time, msg);
      mismatches++;
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) begin
        report($sformatf("result %0d field %s: got %h, expected %h",
                         results_checked, name, got, want));
      end
    endtask

    task check_result(srwo_out_t got);
      srwo_out_t want;
      if (filtered_writes.size() == 0) begin
        report($sformatf("result with address %h arrived with nothing outstanding",
                         got.out_addr));
      end else begin
        want = filtered_writes.pop_front();
        compare_field("out_addr",       got.out_addr,       want.out_addr);
        compare_field("out_value",      got.out_value,      want.out_value);
        compare_field("seen_gain",      got.seen_gain,      want.seen_gain);
        compare_field("seen_preamp",    got.seen_preamp,    want.seen_preamp);
        compare_field("seen_fe",        got.seen_fe,        want.seen_fe);
        compare_field("seen_black_ref", got.seen_black_ref, want.seen_black_ref);
        compare_field("seen_top_ob",    got.seen_top_ob,    want.seen_top_ob);
      end
      results_checked++;
    endtask
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CfgIdxWidth-1:0]  cfg_idx_i;
  logic [CfgDataWidth-1:0] cfg_wdata_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  srwo_in_t                write_beat;
  logic                    out_valid_o;
  logic                    out_ready_i;
  srwo_out_t               result_beat;

  override_scoreboard sb;

  // When set, both sides run without gaps so the queue streams at full rate.
  bit          full_speed;
  int unsigned writes_sent;
  int unsigned settings_applied;
  int unsigned idle_cycles;

  sensor_reg_write_override_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (write_beat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (result_beat)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // All stimulus changes at the falling edge; everything below samples at the
  // rising edge, where the block's registered outputs still hold the values
  // from before the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_write(write_beat);
      if (out_valid_o && out_ready_i) sb.check_result(result_beat);
    end
  end

  // Watchdog: any accepted beat or register write counts as progress.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= StallLimit) begin
          $display("[%0t] ERROR: no progress for %0d cycles, %0d results outstanding",
                   $time, StallLimit, sb.pending());
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  function int unsigned draw_gap();
    return full_speed ? 0 : $urandom_range(0, 19);
  endfunction

  // Result side: for every result it draws a stall, then holds ready high until
  // a result beat is taken.
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      int unsigned gap;
      gap = draw_gap();
      if (gap != 0) begin
        out_ready_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  // Sends one register write beat. Entered and left at a falling edge; valid is
  // left high so that a back-to-back beat never drops it, and the caller either
  // sends again or lowers it in the same step.
  task send_write(logic [3:0] cs, logic [15:0] addr, logic [15:0] value);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    write_beat.chip_select = cs;
    write_beat.reg_addr    = addr;
    write_beat.reg_value   = value;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    writes_sent++;
  endtask

  // Holds the input side off until every predicted result has come out, which
  // leaves the block idle for register writes.
  task wait_until_drained();
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task write_reg(logic [CfgIdxWidth-1:0] idx, int value);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = value[CfgDataWidth-1:0];
    sb.apply_setting(idx, value[CfgDataWidth-1:0]);
    @(negedge clk_i);
  endtask

  // Writes all six registers, then both spare indexes with junk that the block
  // has to ignore.
  task write_settings(int enable, int gain, int preamp, int fe, int black_ref, int top_ob);
    write_reg(CFG_ENABLE,    enable);
    write_reg(CFG_GAIN,      gain);
    write_reg(CFG_PREAMP,    preamp);
    write_reg(CFG_FE,        fe);
    write_reg(CFG_BLACK_REF, black_ref);
    write_reg(CFG_TOP_OB,    top_ob);
    write_reg(CfgIdxSpare0,  $urandom);
    write_reg(CfgIdxSpare1,  $urandom);
    cfg_we_i = 1'b0;
    settings_applied++;
  endtask

  // Random settings, weighted toward the extremes. Some values lie past the
  // documented range on purpose: the block must take the register bits as is.
  task automatic write_random_settings();
    int gain_pick [4]   = '{0, 5000, 8191, 16383};
    int preamp_pick [5] = '{-1, 0, 256, 511, -512};
    int fe_pick [4]     = '{-1, 0, 7, -8};
    int black_pick [4]  = '{0, 1, 8192, 16383};
    int ob_pick [5]     = '{-1, 0, 2000, 2047, -2048};
    int enable;
    int gain;
    int preamp;
    int fe;
    int black_ref;
    int top_ob;
    enable    = int'($urandom_range(0, 5) != 0);
    gain      = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 5000)
                                            : gain_pick[$urandom_range(0, 3)];
    preamp    = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 256)
                                            : preamp_pick[$urandom_range(0, 4)];
    fe        = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 7)
                                            : fe_pick[$urandom_range(0, 3)];
    black_ref = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 8192)
                                            : black_pick[$urandom_range(0, 3)];
    top_ob    = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 2000)
                                            : ob_pick[$urandom_range(0, 4)];
    write_settings(enable, gain, preamp, fe, black_ref, top_ob);
  endtask

  // Chip select for a rule's register: mostly one that the rule accepts, now and
  // then any select, which usually breaks the match.
  function logic [3:0] rule_cs(logic [3:0] wanted);
    if ($urandom_range(0, 7) == 0) return 4'($urandom_range(0, 15));
    return wanted;
  endfunction

  function logic [3:0] main_or_alt_cs();
    return rule_cs(($urandom_range(0, 1) != 0) ? CsMain : CsAlt);
  endfunction

  // One burst of writes as a sensor setup would issue them, with random values.
  // Roughly a quarter of the bursts are plain noise on the bus.
  task send_sequence();
    logic [15:0] value;
    case ($urandom_range(0, 7))
      0: begin
        send_write(rule_cs(CsMain), AddrGain0, 16'($urandom));
        send_write(main_or_alt_cs(), AddrGain1, 16'($urandom));
        send_write(main_or_alt_cs(), AddrGain2, 16'($urandom));
        send_write(main_or_alt_cs(), AddrGain3, 16'($urandom));
      end
      1: begin
        send_write(rule_cs(CsMain), AddrPreampLo, 16'($urandom));
        for (logic [15:0] a = AddrPreampLo + 16'd1; a <= AddrPreampHi; a++) begin
          send_write(main_or_alt_cs(), a, 16'($urandom));
        end
      end
      2: send_write(main_or_alt_cs(), AddrFe, 16'($urandom));
      3: begin
        // Zero values keep the black reference capture armed a little longer.
        value = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom);
        send_write(rule_cs(CsBlack), AddrBlackRef, value);
      end
      4: send_write(4'($urandom_range(0, 15)), AddrTopOb, 16'($urandom));
      5: send_write(4'($urandom_range(0, 15)), AddrTerminator, ValueTerminator);
      default: begin
        send_write(4'($urandom_range(0, 15)), 16'($urandom), 16'($urandom));
        send_write(4'($urandom_range(0, 15)), 16'($urandom_range(0, 255)), 16'($urandom));
      end
    endcase
  endtask

  initial begin
    int unsigned directed_writes;
    int unsigned phase_start;
    sb          = new();
    full_speed  = 1'b0;
    writes_sent = 0;
    settings_applied = 0;
    idle_cycles = 0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_ENABLE;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    write_beat  = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Out of reset the filter is disabled: rule registers pass untouched and
    // nothing is captured.
    send_write(CsMain, AddrGain0, 16'hBEEF);
    send_write(CsMain, AddrTopOb, 16'hFFFF);
    wait_until_drained();

    // Every override at its upper extreme.
    write_settings(1, 5000, 256, 7, 8192, 2000);
    send_write(CsMain, AddrGain0, 16'h1234);
    send_write(CsAlt, AddrGain3, 16'hFFFF);
    send_write(CsMain, AddrPreampLo, 16'h0100);
    send_write(CsAlt, AddrPreampHi, 16'h0000);
    send_write(CsMain, AddrFe, 16'hABCD);
    send_write(CsAlt, AddrFe, 16'h5A5A);
    // A zero black reference leaves the capture armed; the first nonzero one
    // sticks and later writes do not move it.
    send_write(CsBlack, AddrBlackRef, 16'h0000);
    send_write(CsBlack, AddrBlackRef, 16'h0F0F);
    send_write(CsBlack, AddrBlackRef, 16'hFFFF);
    send_write(4'd9, AddrTopOb, 16'hFFFF);
    send_write(4'd0, AddrTopOb, 16'h8000);
    send_write(CsMain, AddrTerminator, ValueTerminator);
    // Near misses: wrong select for a rule, and addresses just outside the
    // preamp window.
    send_write(4'd3, AddrGain0, 16'h7777);
    send_write(CsMain, AddrBlackRef, 16'h2222);
    send_write(CsMain, AddrPreampLo - 16'd1, 16'h0001);
    send_write(CsMain, AddrPreampHi + 16'd1, 16'h0002);
    wait_until_drained();

    // Every override off: capture only.
    write_settings(1, 0, -1, -1, 0, -1);
    send_write(CsMain, AddrGain0, 16'hFFFF);
    send_write(CsMain, AddrPreampLo, 16'hFFFF);
    send_write(CsMain, AddrFe, 16'h0000);
    send_write(CsAlt, AddrTopOb, 16'h5555);
    wait_until_drained();

    // Register values beyond their documented range; the preamp adjustment
    // wraps because the captured default is far above the value.
    write_settings(1, 16383, 511, -8, 16383, 2047);
    send_write(CsAlt, AddrGain2, 16'h0001);
    send_write(CsMain, 16'h0009, 16'h0000);
    send_write(CsMain, AddrTopOb, 16'h0001);
    send_write(CsBlack, AddrBlackRef, 16'h4444);
    directed_writes = writes_sent;

    // Random part: each phase starts from an idle block with fresh settings.
    // One phase runs both sides without gaps to keep the queue streaming.
    for (int phase = 0; phase < RandomPhases; phase++) begin
      wait_until_drained();
      write_random_settings();
      full_speed = (phase == RandomPhases - 3);
      phase_start = writes_sent;
      while (writes_sent - phase_start < WritesPerPhase) send_sequence();
    end
    full_speed = 1'b0;

    wait_until_drained();
    repeat (DrainCycles) @(negedge clk_i);
    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d results never arrived", sb.pending()));
    end

    $display("Sent %0d register writes (%0d directed) under %0d register settings,",
             writes_sent, directed_writes, settings_applied);
    $display("covering all five rules, the disabled path, the terminator and noise.");
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
